### rtl/core/double_hash_table_core_assert.svh
// Assertion macros used by the double hash table controller.
`ifndef DOUBLE_HASH_TABLE_CORE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_CORE_ASSERT_SVH
// Implication checked on every rising clock edge while out of reset.
`define DHT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked while out of reset.
`define DHT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/dht_pkg.sv
// Package with types, constants and codes for the double hash table core.
`timescale 1ns / 1ps
package dht_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int KEY_W = 31;
    localparam int SKEY_W = 32;
    localparam int SIZE_W = 7;
    localparam int SLOT_W = 6;
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_DUMP = 2'd3;
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED = 2'd1;
    localparam logic [1:0] MARK_GONE = 2'd2;

    typedef struct packed {
        logic load;
        logic mod_start;
        logic step;
        logic wr_ins;
        logic wr_rem;
        logic dump_load;
        logic dump_next;
        logic res_hit;
        logic res_miss;
        logic res_dump;
    } dht_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic probe_last;
        logic key_match;
        logic mark_empty;
        logic mark_used;
        logic dump_last;
    } dht_status_t;
endpackage

### rtl/core/dht_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule

### rtl/core/dht_mod.sv
// Restoring modulo unit that computes the key modulo m and m-1, one bit a cycle.
`timescale 1ns / 1ps
module dht_mod import dht_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [KEY_W-1:0]  key,
    input  logic [SIZE_W-1:0] m,
    output logic              done,
    output logic [SIZE_W-1:0] rem_m,
    output logic [SIZE_W-1:0] rem_m1
);
    localparam int CNT_W = $clog2(KEY_W + 1);
    logic [KEY_W-1:0]  sh_reg, sh_next;
    logic [SIZE_W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [SIZE_W:0]   t0, t1;
    logic [SIZE_W-1:0] m1;

    assign m1 = m - SIZE_W'(1);

    always_comb begin
        t0 = {r0_reg, sh_reg[KEY_W-1]};
        t1 = {r1_reg, sh_reg[KEY_W-1]};
        sh_next = sh_reg;
        r0_next = r0_reg;
        r1_next = r1_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            sh_next = key;
            r0_next = '0;
            r1_next = '0;
            cnt_next = CNT_W'(KEY_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            sh_next = {sh_reg[KEY_W-2:0], 1'b0};
            r0_next = (t0 >= {1'b0, m}) ? SIZE_W'(t0 - {1'b0, m}) : SIZE_W'(t0);
            r1_next = (t1 >= {1'b0, m1}) ? SIZE_W'(t1 - {1'b0, m1}) : SIZE_W'(t1);
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        sh_reg <= sh_next;
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

    assign done = done_reg;
    assign rem_m = r0_reg;
    assign rem_m1 = r1_reg;
endmodule

### rtl/core/dht_datapath.sv
// Datapath: slot memories, probe address, clearing sweep and result register.
`timescale 1ns / 1ps
module dht_datapath import dht_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dht_cmd_t          cmd,
    output dht_status_t       stat,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic [KEY_W-1:0]  in_key,
    input  logic              clr_en,
    input  logic [SLOT_W-1:0] clr_addr,
    output logic              res_status,
    output logic [SLOT_W-1:0] res_slot,
    output logic [SKEY_W-1:0] res_key,
    output logic              res_last
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [SIZE_W-1:0] DEPTH_V = SIZE_W'(TABLE_DEPTH);

    logic [SIZE_W-1:0] size_reg, m;
    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] pos_reg, pos_next, step_reg, i_reg;
    logic [SIZE_W:0]   pos_sum;
    logic [AW-1:0]     addr;
    logic              we;
    logic [SKEY_W-1:0] kwd, krd;
    logic [1:0]        mwd, mrd;
    logic              mod_done;
    logic [SIZE_W-1:0] rem_m, rem_m1;

    assign m = (size_reg < SIZE_W'(2)) ? SIZE_W'(2) :
               (size_reg > DEPTH_V) ? DEPTH_V : size_reg;

    dht_mod u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.mod_start), .key(in_key), .m(m),
        .done(mod_done), .rem_m(rem_m), .rem_m1(rem_m1)
    );

    assign pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_next = (pos_sum >= {1'b0, m}) ? SIZE_W'(pos_sum - {1'b0, m})
                                             : SIZE_W'(pos_sum);
    assign addr = clr_en ? clr_addr[AW-1:0] : pos_reg[AW-1:0];
    assign we = clr_en | cmd.wr_ins | cmd.wr_rem;
    assign kwd = cmd.wr_ins ? {1'b0, key_reg} : '1;
    assign mwd = cmd.wr_ins ? MARK_USED : (cmd.wr_rem ? MARK_GONE : MARK_EMPTY);

    dht_ram #(.WIDTH(SKEY_W), .DEPTH(TABLE_DEPTH)) u_keys (
        .aclk(aclk), .we(we), .addr(addr), .wdata(kwd), .rdata(krd)
    );
    dht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_marks (
        .aclk(aclk), .we(we), .addr(addr), .wdata(mwd), .rdata(mrd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= DEPTH_V;
        end else if (cfg_we) begin
            size_reg <= cfg_data;
        end
        if (cmd.load) key_reg <= in_key;
        if (mod_done) begin
            pos_reg <= rem_m;
            step_reg <= rem_m1 + SIZE_W'(1);
            i_reg <= '0;
        end else if (cmd.dump_load) begin
            pos_reg <= '0;
        end else if (cmd.dump_next) begin
            pos_reg <= pos_reg + SIZE_W'(1);
        end else if (cmd.step) begin
            pos_reg <= pos_next;
            i_reg <= i_reg + SIZE_W'(1);
        end
        if (cmd.res_hit) begin
            res_status <= 1'b0;
            res_slot <= SLOT_W'(pos_reg);
            res_key <= cmd.wr_ins ? {1'b0, key_reg} : (cmd.wr_rem ? '1 : krd);
            res_last <= 1'b1;
        end else if (cmd.res_miss) begin
            res_status <= 1'b1;
            res_slot <= '0;
            res_key <= '1;
            res_last <= 1'b1;
        end else if (cmd.res_dump) begin
            res_status <= 1'b0;
            res_slot <= SLOT_W'(pos_reg);
            res_key <= krd;
            res_last <= (pos_reg == m - SIZE_W'(1));
        end
    end

    assign stat.mod_done = mod_done;
    assign stat.probe_last = (i_reg == m - SIZE_W'(1));
    assign stat.key_match = (krd == {1'b0, key_reg});
    assign stat.mark_empty = (mrd == MARK_EMPTY);
    assign stat.mark_used = (mrd == MARK_USED);
    assign stat.dump_last = (pos_reg == m - SIZE_W'(1));
endmodule

### rtl/core/dht_ctrl.sv
// Controller state machine sequencing clear, probes, dump and the output handshake.
`timescale 1ns / 1ps
module dht_ctrl import dht_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    output logic              m_valid,
    input  logic              m_ready,
    input  dht_status_t       stat,
    output dht_cmd_t          cmd,
    output logic              clr_en,
    output logic [SLOT_W-1:0] clr_addr
);
    `include "double_hash_table_core_assert.svh"
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MOD = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_EVAL = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;
    localparam logic [2:0] ST_DREAD = 3'd6;
    localparam logic [2:0] ST_DEVAL = 3'd7;
    localparam logic [SLOT_W-1:0] CLR_END = SLOT_W'(TABLE_DEPTH - 1);

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic              mv_reg, mv_next;

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign clr_en = (state_reg == ST_CLEAR);
    assign clr_addr = clr_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        mv_next = mv_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_END) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    if (s_mode == MODE_DUMP) begin
                        cmd.dump_load = 1'b1;
                        state_next = ST_DREAD;
                    end else begin
                        cmd.mod_start = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (stat.mod_done) state_next = ST_READ;
            end
            ST_READ: state_next = ST_EVAL;
            ST_EVAL: begin
                if (mode_reg == MODE_INSERT) begin
                    if (!stat.mark_used) begin
                        cmd.wr_ins = 1'b1;
                        cmd.res_hit = 1'b1;
                        state_next = ST_OUT;
                    end
                end else if (stat.key_match) begin
                    cmd.wr_rem = (mode_reg == MODE_REMOVE);
                    cmd.res_hit = 1'b1;
                    state_next = ST_OUT;
                end else if (stat.mark_empty) begin
                    cmd.res_miss = 1'b1;
                    state_next = ST_OUT;
                end
                if (state_next == ST_EVAL) begin
                    if (stat.probe_last) begin
                        cmd.res_miss = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        cmd.step = 1'b1;
                        state_next = ST_READ;
                    end
                end
                if (state_next == ST_OUT) begin
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DREAD: begin
                if (!mv_reg || m_ready) state_next = ST_DEVAL;
            end
            ST_DEVAL: begin
                cmd.res_dump = 1'b1;
                mv_next = 1'b1;
                if (stat.dump_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.dump_next = 1'b1;
                    state_next = ST_DREAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + SLOT_W'(1);
        end
        if (cmd.load) mode_reg <= s_mode;
    end

    `DHT_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_ready,
        "input accepted during clear")
    `DHT_ASSERT_IMP(a_dump_free, aclk, aresetn, state_reg == ST_DEVAL, !mv_reg || m_ready,
        "dump overwrote a pending word")
    `DHT_ASSERT_NEXT(a_eval_write, aclk, aresetn, cmd.wr_ins || cmd.wr_rem, m_valid,
        "write without a result")
    `DHT_ASSERT_IMP(a_one_write, aclk, aresetn, 1'b1, !(cmd.wr_ins && cmd.wr_rem),
        "insert and remove together")
endmodule

### rtl/core/double_hash_table_core.sv
// Insert/search/remove first run the bit-serial modulo, then probe slots, each a read and an evaluation.
// One operation at a time: no new word is accepted until the previous result has been taken.
// Dump gives one word per slot, alternating a registered slot memory read and an evaluation.
// Reset: synchronous active-low; a clearing pass over all TABLE_DEPTH slots follows,
// with no input word accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
module double_hash_table_core import dht_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [KEY_W-1:0]  s_key,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_status,
    output logic [SLOT_W-1:0] m_slot,
    output logic [SKEY_W-1:0] m_slot_key_out,
    output logic              m_last
);
    dht_cmd_t          cmd;
    dht_status_t       stat;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_addr;

    dht_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .m_valid(m_valid), .m_ready(m_ready), .stat(stat),
        .cmd(cmd), .clr_en(clr_en), .clr_addr(clr_addr)
    );

    dht_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .in_key(s_key), .clr_en(clr_en), .clr_addr(clr_addr),
        .res_status(m_status), .res_slot(m_slot), .res_key(m_slot_key_out),
        .res_last(m_last)
    );
endmodule
